// ----- rtl/core/sdtq_pkg.sv -----
// Shared types and codes for the sorted deadline timer queue.
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [2:0] STATUS_DONE      = 3'd0;
    localparam logic [2:0] STATUS_FOUND     = 3'd1;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_NOT_DUE   = 3'd4;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INSERT,
        MODE_REMOVE
    } t_mode;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  cls;
        logic [7:0]  kind;
    } t_entry;

    typedef struct packed {
        logic  cmp;
        logic  upd;
        t_mode mode;
    } t_cell_ctrl;

endpackage

// ----- rtl/core/sdtq_cell.sv -----
// One queue slot: compares against the request and shifts with its neighbors.
`timescale 1ns / 1ps

module sdtq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdtq_pkg::t_cell_ctrl i_ctrl,
    input  sdtq_pkg::t_entry    i_new,
    input  sdtq_pkg::t_entry    i_left,
    input  logic                i_left_valid,
    input  sdtq_pkg::t_entry    i_right,
    input  logic                i_right_valid,
    input  logic                i_chain,
    output logic                o_chain,
    output sdtq_pkg::t_entry    o_entry,
    output logic                o_valid,
    output sdtq_pkg::t_entry    o_next_entry,
    output logic                o_next_valid
);

    sdtq_pkg::t_entry r_entry;
    sdtq_pkg::t_entry n_entry;
    logic             r_valid;
    logic             n_valid;
    logic             r_not_before;
    logic             r_match;
    logic [31:0]      w_diff;
    logic             w_before;
    logic             w_match;
    logic             w_hit;

    assign w_diff   = r_entry.deadline - i_new.deadline;
    assign w_before = r_valid && w_diff[31];
    assign w_match  = r_valid && (r_entry.src == i_new.src) && (r_entry.dst == i_new.dst)
                      && (r_entry.cls == i_new.cls) && (r_entry.kind == i_new.kind);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_not_before <= !w_before;
            r_match      <= w_match;
        end
    end

    assign w_hit   = (i_ctrl.mode == sdtq_pkg::MODE_INSERT) ? r_not_before : r_match;
    assign o_chain = i_chain | w_hit;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        unique case (i_ctrl.mode)
            sdtq_pkg::MODE_INSERT: begin
                if (i_chain) begin
                    n_entry = i_left;
                    n_valid = i_left_valid;
                end else if (r_not_before) begin
                    n_entry = i_new;
                    n_valid = 1'b1;
                end
            end
            sdtq_pkg::MODE_REMOVE: begin
                if (i_chain || r_match) begin
                    n_entry = i_right;
                    n_valid = i_right_valid;
                end
            end
            default: begin
                n_entry = r_entry;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.upd) begin
            r_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.upd) begin
            r_valid <= n_valid;
        end
    end

    assign o_entry      = r_entry;
    assign o_valid      = r_valid;
    assign o_next_entry = n_entry;
    assign o_next_valid = n_valid;

endmodule

// ----- rtl/core/sorted_deadline_timer_queue.sv -----
// Top level of the sorted deadline timer queue: request control and the cell chain.
`timescale 1ns / 1ps

// Deadline-ordered timer queue of QUEUE_DEPTH entries held in a chain of cells, head in
// cell 0. Each request has a compare step (every cell compares its entry with the request:
// deadline order and key match) and an update step (entries from the insert point on move
// one place tailward, or those behind a removed entry headward; a find, full insert or
// not-due pop moves nothing). A new request is taken in the cycle a result is written;
// a stalled result holds the queue until it is taken. No clearing pass after reset.

module sorted_deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [7:0]  i_service_class,
    input  logic [7:0]  i_task_kind,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_popped_src,
    output logic [31:0] o_popped_dst,
    output logic [7:0]  o_popped_class,
    output logic [7:0]  o_popped_kind,
    output logic        o_head_valid,
    output logic [31:0] o_wait_ms
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [1:0]           r_op;
    logic [31:0]          r_now;
    sdtq_pkg::t_entry     r_req;
    sdtq_pkg::t_mode      r_mode;
    logic                 r_due;
    logic                 r_full;
    logic                 r_out_valid;
    logic [2:0]           r_status;
    sdtq_pkg::t_entry     r_popped;
    logic                 r_head_valid;
    logic [31:0]          r_wait;

    sdtq_pkg::t_cell_ctrl w_ctrl;
    sdtq_pkg::t_entry     w_entry [QUEUE_DEPTH];
    logic                 w_valid [QUEUE_DEPTH];
    sdtq_pkg::t_entry     w_next_entry [QUEUE_DEPTH];
    logic                 w_next_valid [QUEUE_DEPTH];
    logic                 w_chain [QUEUE_DEPTH+1];
    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_finish;
    logic [31:0]          w_head_diff;
    logic [31:0]          w_wait_diff;
    logic [2:0]           w_status;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_UPD) && w_out_free;
    assign o_in_stall = !((r_state == S_IDLE) || w_finish);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (w_finish) n_state = w_accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op           <= i_operation;
            r_now          <= i_now_ms;
            r_req.deadline <= i_now_ms + i_delay_ms;
            r_req.src      <= i_src_addr;
            r_req.dst      <= i_dst_addr;
            r_req.cls      <= i_service_class;
            r_req.kind     <= i_task_kind;
        end
    end

    assign w_head_diff = w_entry[0].deadline - r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sdtq_pkg::MODE_HOLD;
        end else if (r_state == S_CMP) begin
            unique case (r_op)
                sdtq_pkg::OP_INSERT:
                    r_mode <= w_valid[QUEUE_DEPTH-1] ? sdtq_pkg::MODE_HOLD
                                                     : sdtq_pkg::MODE_INSERT;
                sdtq_pkg::OP_DELETE:
                    r_mode <= sdtq_pkg::MODE_REMOVE;
                sdtq_pkg::OP_POP:
                    r_mode <= (w_valid[0] && w_head_diff[31]) ? sdtq_pkg::MODE_REMOVE
                                                              : sdtq_pkg::MODE_HOLD;
                default:
                    r_mode <= sdtq_pkg::MODE_HOLD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            r_due  <= w_valid[0] && w_head_diff[31];
            r_full <= w_valid[QUEUE_DEPTH-1];
        end
    end

    assign w_ctrl.cmp  = (r_state == S_CMP);
    assign w_ctrl.upd  = w_finish;
    assign w_ctrl.mode = (r_state == S_UPD) ? r_mode : sdtq_pkg::MODE_HOLD;

    assign w_chain[0] = (r_op == sdtq_pkg::OP_POP) && r_due;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        sdtq_pkg::t_entry w_left;
        sdtq_pkg::t_entry w_right;
        logic             w_left_valid;
        logic             w_right_valid;

        if (g == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_valid = 1'b0;
        end else begin : g_mid_left
            assign w_left       = w_entry[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right       = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_right
            assign w_right       = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        sdtq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new         (r_req),
            .i_left        (w_left),
            .i_left_valid  (w_left_valid),
            .i_right       (w_right),
            .i_right_valid (w_right_valid),
            .i_chain       (w_chain[g]),
            .o_chain       (w_chain[g+1]),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_next_entry  (w_next_entry[g]),
            .o_next_valid  (w_next_valid[g])
        );
    end

    always_comb begin
        unique case (r_op)
            sdtq_pkg::OP_INSERT:
                w_status = r_full ? sdtq_pkg::STATUS_FULL : sdtq_pkg::STATUS_DONE;
            sdtq_pkg::OP_FIND:
                w_status = w_chain[QUEUE_DEPTH] ? sdtq_pkg::STATUS_FOUND
                                                : sdtq_pkg::STATUS_NOT_FOUND;
            sdtq_pkg::OP_DELETE:
                w_status = w_chain[QUEUE_DEPTH] ? sdtq_pkg::STATUS_DONE
                                                : sdtq_pkg::STATUS_NOT_FOUND;
            default:
                w_status = r_due ? sdtq_pkg::STATUS_DONE : sdtq_pkg::STATUS_NOT_DUE;
        endcase
    end

    assign w_wait_diff = w_next_entry[0].deadline - r_now;

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_status     <= w_status;
            r_popped     <= w_chain[0] ? w_entry[0] : '0;
            r_head_valid <= w_next_valid[0];
            r_wait       <= (w_next_valid[0] && !w_wait_diff[31]) ? w_wait_diff : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_src   = r_popped.src;
    assign o_popped_dst   = r_popped.dst;
    assign o_popped_class = r_popped.cls;
    assign o_popped_kind  = r_popped.kind;
    assign o_head_valid   = r_head_valid;
    assign o_wait_ms      = r_wait;

endmodule
